/* rtl/char_stack_with_extract_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the character stack
// Shorthand for clocked assertions that share the clock and reset names.
// ----------------------------------------------------------------------------
`ifndef CHAR_STACK_WITH_EXTRACT_MACROS_SVH
`define CHAR_STACK_WITH_EXTRACT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/csx_pkg.sv */
// ----------------------------------------------------------------------------
// Character stack package
// Shared types and constants for the stack controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package csx_pkg;

  // Default number of stack entries.
  localparam int unsigned DefaultDepth = 32;

  // Fixed payload widths.
  localparam int unsigned FuncW  = 2;
  localparam int unsigned CharW  = 8;
  localparam int unsigned LevelW = 6;

  // A space is never stored.
  localparam logic [CharW-1:0] SpaceChar = 8'h20;

  // Operation selector.
  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_EXTRACT = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_NONE  = 2'd3
  } status_e;

  // Data source of a single result.
  typedef enum logic {
    SEL_ZERO = 1'b0,
    SEL_POP  = 1'b1
  } out_sel_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_RESULT,
    S_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     in_ready;
    logic     latch;
    logic     push_wr;
    logic     pop_rd;
    logic     walk_init;
    logic     walk_step;
    logic     walk_commit;
    logic     res_set;
    status_e  res_status;
    out_sel_e res_sel;
    logic     out_load;
    logic     out_emit;
    logic     rm_dec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_e func;
    logic  full;
    logic  empty;
    logic  is_space;
    logic  walk_done;
    logic  none_found;
    logic  rm_one;
    logic  slot_free;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/csx_in_if.sv */
// ----------------------------------------------------------------------------
// Stack request channel
// Valid/ready channel that carries one operation and its character.
// ----------------------------------------------------------------------------
`default_nettype none

interface csx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] ch;

  modport source (output valid, output func, output ch, input ready);
  modport sink   (input valid, input func, input ch, output ready);
endinterface

`default_nettype wire

/* rtl/csx_out_if.sv */
// ----------------------------------------------------------------------------
// Stack result channel
// Valid/ready channel that carries one result of an operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface csx_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_out;
  logic       last;
  logic [5:0] level;

  modport source (output valid, output status, output data_out, output last,
                  output level, input ready);
  modport sink   (input valid, input status, input data_out, input last,
                  input level, output ready);
endinterface

`default_nettype wire

/* rtl/csx_ctrl.sv */
// ----------------------------------------------------------------------------
// Character stack controller
// State machine that sequences push, pop and the extract walk and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module csx_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire csx_pkg::sts_t sts_i,
  output csx_pkg::cmd_t      cmd_o
);
  import csx_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.func == FUNC_EXTRACT && !sts_i.empty) begin
          state_d = S_WALK;
        end else begin
          state_d = S_RESULT;
        end
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          state_d = sts_i.none_found ? S_RESULT : S_EMIT;
        end
      end
      S_RESULT: begin
        if (sts_i.slot_free) begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.slot_free && sts_i.rm_one) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    cmd_o.res_sel    = SEL_ZERO;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.latch    = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.res_set = 1'b1;
        case (sts_i.func)
          FUNC_PUSH: begin
            if (sts_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.push_wr = !sts_i.is_space;
            end
          end
          FUNC_POP: begin
            if (sts_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.pop_rd  = 1'b1;
              cmd_o.res_sel = SEL_POP;
            end
          end
          FUNC_EXTRACT: begin
            if (sts_i.empty) begin
              cmd_o.res_status = ST_EMPTY;
            end else begin
              cmd_o.walk_init = 1'b1;
            end
          end
          default: begin
            cmd_o.res_status = ST_OK;
          end
        endcase
      end
      S_WALK: begin
        if (sts_i.walk_done) begin
          if (sts_i.none_found) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NONE;
          end else begin
            cmd_o.walk_commit = 1'b1;
          end
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_RESULT: begin
        cmd_o.out_load = sts_i.slot_free;
      end
      S_EMIT: begin
        cmd_o.out_load = sts_i.slot_free;
        cmd_o.out_emit = 1'b1;
        cmd_o.rm_dec   = sts_i.slot_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/csx_dp.sv */
// ----------------------------------------------------------------------------
// Character stack datapath
// Entry memory, fill count, extract walk counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csx_dp #(
  parameter int unsigned DEPTH = csx_pkg::DefaultDepth
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire csx_pkg::cmd_t              cmd_i,
  output csx_pkg::sts_t                   sts_o,
  input  wire logic [csx_pkg::FuncW-1:0]  func_i,
  input  wire logic [csx_pkg::CharW-1:0]  ch_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      out_status_o,
  output logic [csx_pkg::CharW-1:0]       out_data_o,
  output logic                            out_last_o,
  output logic [csx_pkg::LevelW-1:0]      out_level_o
);
  import csx_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] One   = CntW'(1);
  localparam logic [CntW-1:0] Full  = CntW'(DEPTH);

  // Entry memory with registered read data.
  logic [CharW-1:0] mem [DEPTH];
  logic [CharW-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    waddr, raddr;
  logic [CharW-1:0] wdata;

  // Latched request.
  logic [FuncW-1:0] func_q;
  logic [CharW-1:0] ch_q;

  // Fill count and walk state.
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] rd_q, rd_d;
  logic [CntW-1:0] wr_q, wr_d;
  logic [CntW-1:0] rm_q, rm_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] cnt_m1;
  logic            issue, match;

  // Pending single result.
  status_e  res_status_q;
  out_sel_e res_sel_q;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q;
  logic [CharW-1:0] out_data_q;
  logic             out_last_q;
  logic [LevelW-1:0] out_level_q;
  logic [CntW+LevelW-1:0] lvl_ext;

  assign cnt_m1 = cnt_q - One;
  assign issue  = rd_q != cnt_q;
  assign match  = rdata_q == ch_q;

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    waddr  = cnt_q[AW-1:0];
    wdata  = ch_q;
    mem_re = 1'b0;
    raddr  = rd_q[AW-1:0];
    if (cmd_i.push_wr) begin
      mem_we = 1'b1;
    end else if (cmd_i.walk_step && pend_q && !match) begin
      mem_we = 1'b1;
      waddr  = wr_q[AW-1:0];
      wdata  = rdata_q;
    end
    if (cmd_i.pop_rd) begin
      mem_re = 1'b1;
      raddr  = cnt_m1[AW-1:0];
    end else if (cmd_i.walk_step && issue) begin
      mem_re = 1'b1;
    end
  end

  // Memory array.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Count and walk next values.
  always_comb begin
    cnt_d  = cnt_q;
    rd_d   = rd_q;
    wr_d   = wr_q;
    rm_d   = rm_q;
    pend_d = pend_q;
    if (cmd_i.push_wr) begin
      cnt_d = cnt_q + One;
    end
    if (cmd_i.pop_rd) begin
      cnt_d = cnt_m1;
    end
    if (cmd_i.walk_commit) begin
      cnt_d = wr_q;
    end
    if (cmd_i.walk_init) begin
      rd_d   = '0;
      wr_d   = '0;
      rm_d   = '0;
      pend_d = 1'b0;
    end
    if (cmd_i.walk_step) begin
      pend_d = issue;
      if (issue) begin
        rd_d = rd_q + One;
      end
      if (pend_q) begin
        if (match) begin
          rm_d = rm_q + One;
        end else begin
          wr_d = wr_q + One;
        end
      end
    end
    if (cmd_i.rm_dec) begin
      rm_d = rm_q - One;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      rm_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      rm_q        <= rm_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and pending result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      ch_q   <= ch_i;
    end
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_sel_q    <= cmd_i.res_sel;
    end
  end

  // The result register frees up when its transfer completes.
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Level is the count taken modulo two to the power of the level field width.
  assign lvl_ext = {{LevelW{1'b0}}, cnt_q};

  // Result payload: an extracted character, or the pending single result.
  // The level is captured with the result so that a stalled result keeps it.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_level_q <= lvl_ext[LevelW-1:0];
      if (cmd_i.out_emit) begin
        out_status_q <= ST_OK;
        out_data_q   <= ch_q;
        out_last_q   <= rm_q == One;
      end else begin
        out_status_q <= res_status_q;
        out_data_q   <= (res_sel_q == SEL_POP) ? rdata_q : '0;
        out_last_q   <= 1'b1;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_data_o   = out_data_q;
  assign out_last_o   = out_last_q;
  assign out_level_o  = out_level_q;

  // Status to the controller.
  always_comb begin
    sts_o.func       = func_e'(func_q);
    sts_o.full       = cnt_q == Full;
    sts_o.empty      = cnt_q == '0;
    sts_o.is_space   = ch_q == SpaceChar;
    sts_o.walk_done  = !issue && !pend_q;
    sts_o.none_found = rm_q == '0;
    sts_o.rm_one     = rm_q == One;
    sts_o.slot_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

/* rtl/char_stack_with_extract.sv */
// ----------------------------------------------------------------------------
// Character stack with extract
// Bounded LIFO of characters with push, pop and extract-all-matching.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                          Transfer
//  req_i    in   func[1:0], ch[7:0]               valid && ready
//  rsp_o    out  status, data_out, last, level    valid && ready
//
//  Push, pop, an extract on an empty stack and the unused selector pass
//  through the decode and result states into the output register. Any
//  other extract walks and compacts the entries over the single memory
//  read port, then offers a none-found result or each removed character,
//  one result per cycle while the output is not stalled. Entries are
//  never cleared, so no pass runs after reset. A stalled result holds in
//  the output register with its level; the next request is taken once
//  the last result of the current one has entered that register.
// ----------------------------------------------------------------------------
`default_nettype none

module char_stack_with_extract #(
  parameter int unsigned DEPTH = csx_pkg::DefaultDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csx_in_if.sink    req_i,
  csx_out_if.source rsp_o
);
  import csx_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  csx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage and result register.
  csx_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (req_i.func),
    .ch_i         (req_i.ch),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_status_o (rsp_o.status),
    .out_data_o   (rsp_o.data_out),
    .out_last_o   (rsp_o.last),
    .out_level_o  (rsp_o.level)
  );

  assign req_i.ready = cmd.in_ready;

endmodule

`default_nettype wire

/* rtl/char_stack_with_extract_checker.sv */
// ----------------------------------------------------------------------------
// Character stack port checker
// Port-level properties of the stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_stack_with_extract_macros.svh"

module char_stack_with_extract_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] out_status_i,
  input wire logic [7:0] out_data_i,
  input wire logic       out_last_i
);
  import csx_pkg::*;

  // A stalled result stays offered.
  `CSX_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // One request at a time: no new transfer right after one is taken.
  `CSX_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_i, !in_ready_i, "request overlap")

  // Error and status results carry no character and end the request.
  `CSX_ASSERT_SAME(a_status_clean, out_valid_i && (out_status_i != ST_OK), (out_data_i == 8'h00) && out_last_i, "bad status result")

  // Only an extract gives several results, all of them successful.
  `CSX_ASSERT_SAME(a_nonlast_ok, out_valid_i && !out_last_i, out_status_i == ST_OK, "bad non-final result")

endmodule

bind char_stack_with_extract char_stack_with_extract_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_status_i (rsp_o.status),
  .out_data_i   (rsp_o.data_out),
  .out_last_i   (rsp_o.last)
);

`default_nettype wire
